// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the speed tuple cover checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define STCC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle after an antecedent.
`define STCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/stcc_pkg.sv =====
// ----------------------------------------------------------------------------
// stcc_pkg
// Shared types and constants of the speed tuple cover checker.
// ----------------------------------------------------------------------------
package stcc_pkg;

  // Datapath width of speeds, modulus and residues.
  localparam int DATA_W     = 16;
  localparam int LEVEL_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int SHIFT_W    = 5;
  localparam int DIV_STEP_W = $clog2(DATA_W);

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_RANGE = 2'd2;

  // One classified speed as it travels from the front to the back.
  typedef struct packed {
    logic [DATA_W-1:0] speed;
    logic              last;
    logic              err;
    logic              drop;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quot;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } gcd_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] g;
  } gcd_rsp_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MOD,
    ST_THR,
    ST_THR_WAIT,
    ST_COV_INIT,
    ST_COV,
    ST_GCD_INIT,
    ST_GCD_PICK,
    ST_GCD_WAIT,
    ST_GCD_CHECK,
    ST_OUT
  } back_state_t;

endpackage

// ===== design/speed_tuple_cover_checker_top.sv =====
// ----------------------------------------------------------------------------
// speed_tuple_cover_checker_top
// Checks one tuple of speeds for position coverage and subset gcd against n.
// ----------------------------------------------------------------------------
// Usage:
//   Speeds enter one per transaction on the in_ channel (push / full); the
//   transaction with in_last set closes the tuple. Exactly one verdict then
//   appears on the out_ channel (empty / pop). The user must write registers
//   modulus, level and full_range through cfg_we / cfg_index / cfg_wdata
//   only while idle; the block itself does not enforce this.
// Per tuple of c stored speeds and P positions (P = Q, or Q/2 in half mode):
//   - loading: the 16-step divider reduces each stored speed modulo Q;
//   - threshold: one more division on the same divider;
//   - coverage: one position per cycle across all lanes, up to P positions;
//   - gcd: up to c*(c-1) calls of the binary gcd unit.
//   A four-entry queue lets the front keep taking speeds while the back works.
// Reset clears the tuple, the queue and the verdict valid flag and restores
// the register defaults; no clearing pass is needed. If the receiver stalls,
// the verdict waits in its output register and the back can load the next
// tuple, holding only when its own verdict is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module speed_tuple_cover_checker_top
  import stcc_pkg::*;
#(
  parameter int MAX_RUNNERS = 16,
  parameter int SPEED_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [DATA_W-1:0]    in_speed,
  input  logic                 in_last,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_is_cover,
  output logic                 out_gcd_ok,
  output logic                 out_coverage_ok,
  output logic                 out_bad_tuple
);

  logic [DATA_W-1:0]  modulus_r, modulus_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               full_range_r, full_range_nxt;
  logic               q_valid;
  logic               q_pop;
  item_t              q_item;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  gcd_req_t           gcd_req;
  gcd_rsp_t           gcd_rsp;

  // Configuration register writes.
  always_comb begin
    modulus_nxt    = modulus_r;
    level_nxt      = level_r;
    full_range_nxt = full_range_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS:    modulus_nxt    = cfg_wdata;
        REG_LEVEL:      level_nxt      = cfg_wdata[LEVEL_W-1:0];
        REG_FULL_RANGE: full_range_nxt = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= DATA_W'(2710);
      level_r      <= LEVEL_W'(10);
      full_range_r <= 1'b1;
    end else begin
      modulus_r    <= modulus_nxt;
      level_r      <= level_nxt;
      full_range_r <= full_range_nxt;
    end
  end

  // Front end: classify and queue speeds.
  stcc_front #(
    .MAX_RUNNERS (MAX_RUNNERS),
    .SPEED_BITS  (SPEED_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_speed (in_speed),
    .in_last  (in_last),
    .in_full  (in_full),
    .modulus  (modulus_r),
    .q_pop    (q_pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  // Shared arithmetic units of the back end.
  stcc_divu u_divu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  stcc_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (gcd_req),
    .rsp   (gcd_rsp)
  );

  // Back end: tuple checks and verdict register.
  stcc_back #(
    .MAX_RUNNERS (MAX_RUNNERS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .modulus         (modulus_r),
    .level           (level_r),
    .full_range      (full_range_r),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .div_req         (div_req),
    .div_rsp         (div_rsp),
    .gcd_req         (gcd_req),
    .gcd_rsp         (gcd_rsp),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_is_cover    (out_is_cover),
    .out_gcd_ok      (out_gcd_ok),
    .out_coverage_ok (out_coverage_ok),
    .out_bad_tuple   (out_bad_tuple)
  );

  // A taken verdict is never replaced in the same cycle.
  `STCC_ASSERT_NEXT(a_pop_then_empty, out_pop && !out_empty, out_empty, "verdict reissued after pop")
  // The back only pops a queue that holds an item.
  `STCC_ASSERT_ALWAYS(a_queue_pop_valid, !q_pop || q_valid, "queue popped while empty")
  // Arithmetic units are only started while idle.
  `STCC_ASSERT_ALWAYS(a_div_idle, !div_req.start || !div_rsp.busy, "divider restarted while busy")
  `STCC_ASSERT_ALWAYS(a_gcd_idle, !gcd_req.start || !gcd_rsp.busy, "gcd unit restarted while busy")

endmodule

// ===== design/stcc_front.sv =====
// ----------------------------------------------------------------------------
// stcc_front
// Accepts speeds, flags range errors and overflow, and queues them.
// ----------------------------------------------------------------------------
module stcc_front
  import stcc_pkg::*;
#(
  parameter int MAX_RUNNERS = 16,
  parameter int SPEED_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [DATA_W-1:0] in_speed,
  input  logic              in_last,
  output logic              in_full,
  input  logic [DATA_W-1:0] modulus,
  input  logic              q_pop,
  output logic              q_valid,
  output item_t             q_item
);

  localparam int SW = (SPEED_BITS < DATA_W) ? SPEED_BITS : DATA_W;
  localparam int CW = $clog2(MAX_RUNNERS + 1);

  logic [CW-1:0]     tuple_cnt_r, tuple_cnt_nxt;
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  item_t             mem_r [QUEUE_DEPTH];
  logic              accept;
  logic              pop_ok;
  logic              drop;
  logic [DATA_W-1:0] speed_masked;
  item_t             new_item;

  // Classify the incoming speed.
  assign accept       = in_push && !in_full;
  assign pop_ok       = q_pop && q_valid;
  assign speed_masked = DATA_W'(in_speed[SW-1:0]);
  assign drop         = (tuple_cnt_r == CW'(MAX_RUNNERS));

  always_comb begin
    new_item.speed = speed_masked;
    new_item.last  = in_last;
    new_item.err   = (speed_masked >= modulus) || drop;
    new_item.drop  = drop;
  end

  // Per-tuple position count, used to detect capacity overflow.
  always_comb begin
    tuple_cnt_nxt = tuple_cnt_r;
    if (accept) begin
      if (in_last) begin
        tuple_cnt_nxt = '0;
      end else if (!drop) begin
        tuple_cnt_nxt = tuple_cnt_r + CW'(1);
      end
    end
  end

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_nxt = accept ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (accept && !pop_ok) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop_ok && !accept) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  assign in_full = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tuple_cnt_r <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
    end else begin
      tuple_cnt_r <= tuple_cnt_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ===== design/stcc_divu.sv =====
// ----------------------------------------------------------------------------
// stcc_divu
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stcc_divu
  import stcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_STEP_W-1:0] step_r, step_nxt;
  logic [DATA_W-1:0]     rem_r, rem_nxt;
  logic [DATA_W-1:0]     quo_r, quo_nxt;
  logic [DATA_W-1:0]     dvs_r, dvs_nxt;
  logic [DATA_W:0]       rem_sh;
  logic                  fits;

  // One shift-and-subtract step.
  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DATA_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], fits};
      if (step_r == DIV_STEP_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + DIV_STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  always_comb begin
    rsp.busy = busy_r;
    rsp.done = done_r;
    rsp.quot = quo_r;
    rsp.rem  = rem_r;
  end

endmodule

// ===== design/stcc_gcd.sv =====
// ----------------------------------------------------------------------------
// stcc_gcd
// Iterative binary gcd unit, one reduction step per cycle.
// ----------------------------------------------------------------------------
module stcc_gcd
  import stcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  gcd_req_t req,
  output gcd_rsp_t rsp
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DATA_W-1:0]  a_r, a_nxt;
  logic [DATA_W-1:0]  b_r, b_nxt;
  logic [SHIFT_W-1:0] k_r, k_nxt;
  logic [DATA_W-1:0]  g_r, g_nxt;

  // Strip common twos, then halve and subtract odd operands.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    g_nxt    = g_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      a_nxt    = req.a;
      b_nxt    = req.b;
      k_nxt    = '0;
    end else if (busy_r) begin
      if (a_r == '0) begin
        g_nxt    = b_r << k_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (b_r == '0) begin
        g_nxt    = a_r << k_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + SHIFT_W'(1);
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r >= b_r) begin
        a_nxt = (a_r - b_r) >> 1;
      end else begin
        b_nxt = (b_r - a_r) >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
    g_r <= g_nxt;
  end

  always_comb begin
    rsp.busy = busy_r;
    rsp.done = done_r;
    rsp.g    = g_r;
  end

endmodule

// ===== design/stcc_back.sv =====
// ----------------------------------------------------------------------------
// stcc_back
// Loads one tuple from the queue, runs coverage and gcd checks, holds verdict.
// ----------------------------------------------------------------------------
module stcc_back
  import stcc_pkg::*;
#(
  parameter int MAX_RUNNERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [DATA_W-1:0]  modulus,
  input  logic [LEVEL_W-1:0] level,
  input  logic               full_range,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output div_req_t           div_req,
  input  div_rsp_t           div_rsp,
  output gcd_req_t           gcd_req,
  input  gcd_rsp_t           gcd_rsp,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_is_cover,
  output logic               out_gcd_ok,
  output logic               out_coverage_ok,
  output logic               out_bad_tuple
);

  localparam int IW = $clog2(MAX_RUNNERS);
  localparam int CW = $clog2(MAX_RUNNERS + 1);
  localparam logic [DATA_W-1:0] ONE = DATA_W'(1);

  back_state_t          state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 err_r, err_nxt;
  logic                 cur_last_r, cur_last_nxt;
  logic [MAX_RUNNERS-1:0] used_r, used_nxt;
  logic [DATA_W-1:0]    lim_r, lim_nxt;
  logic [DATA_W-1:0]    t_r, t_nxt;
  logic [DATA_W-1:0]    top_r, top_nxt;
  logic [IW-1:0]        i_r, i_nxt;
  logic [IW-1:0]        j_r, j_nxt;
  logic [DATA_W-1:0]    g_r, g_nxt;
  logic                 gcd_ok_r, gcd_ok_nxt;
  logic                 cov_r, cov_nxt;
  logic                 res_valid_r, res_valid_nxt;
  logic                 v_cover_r, v_cover_nxt;
  logic                 v_gcd_r, v_gcd_nxt;
  logic                 v_cov_r, v_cov_nxt;
  logic                 v_bad_r, v_bad_nxt;

  // Speed store and per-lane residues; payload only.
  logic [DATA_W-1:0]    store_r [MAX_RUNNERS];
  logic [DATA_W-1:0]    mres_r  [MAX_RUNNERS];
  logic [DATA_W-1:0]    res_r   [MAX_RUNNERS];
  logic [DATA_W-1:0]    step_val [MAX_RUNNERS];
  logic [MAX_RUNNERS-1:0] hit_vec;

  logic                 store_we;
  logic                 lane_we;
  logic                 cov_step;
  logic [IW-1:0]        cnt_idx;
  logic [IW-1:0]        last_idx;
  logic [DATA_W-1:0]    hi_lim;
  logic [DATA_W-1:0]    top_val;
  logic [DATA_W-1:0]    level_ext;
  logic                 any_hit;
  logic                 j_at_end;
  logic                 skip_j;

  assign cnt_idx   = cnt_r[IW-1:0];
  assign last_idx  = IW'(cnt_r - CW'(1));
  assign hi_lim    = modulus - lim_r;
  assign top_val   = full_range ? modulus : (modulus >> 1);
  assign level_ext = DATA_W'(level);
  assign any_hit   = |hit_vec;
  assign j_at_end  = (j_r == last_idx);
  assign skip_j    = (j_r == i_r) || (g_r == ONE);

  // Coverage lanes: hit test and residue advance by the speed modulo Q.
  for (genvar k = 0; k < MAX_RUNNERS; k++) begin : g_lane
    logic [DATA_W:0] sum;
    assign sum         = {1'b0, res_r[k]} + {1'b0, mres_r[k]};
    assign step_val[k] = (sum >= {1'b0, modulus}) ? DATA_W'(sum - {1'b0, modulus})
                                                  : sum[DATA_W-1:0];
    assign hit_vec[k]  = used_r[k] && ((res_r[k] <= lim_r) || (res_r[k] >= hi_lim));
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (q_valid) begin
          if (!q_item.drop) begin
            state_nxt = ST_MOD;
          end else if (q_item.last) begin
            state_nxt = ST_THR;
          end
        end
      end
      ST_MOD: begin
        if (div_rsp.done) begin
          state_nxt = cur_last_r ? ST_THR : ST_LOAD;
        end
      end
      ST_THR: begin
        state_nxt = ST_THR_WAIT;
      end
      ST_THR_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_COV_INIT;
        end
      end
      ST_COV_INIT: begin
        state_nxt = ((modulus == '0) || (top_val == '0)) ? ST_GCD_INIT : ST_COV;
      end
      ST_COV: begin
        if (!any_hit || (t_r == top_r)) begin
          state_nxt = ST_GCD_INIT;
        end
      end
      ST_GCD_INIT: begin
        state_nxt = ST_GCD_PICK;
      end
      ST_GCD_PICK: begin
        if (!skip_j) begin
          state_nxt = ST_GCD_WAIT;
        end else if (j_at_end) begin
          state_nxt = ST_GCD_CHECK;
        end
      end
      ST_GCD_WAIT: begin
        if (gcd_rsp.done) begin
          state_nxt = j_at_end ? ST_GCD_CHECK : ST_GCD_PICK;
        end
      end
      ST_GCD_CHECK: begin
        if ((g_r != ONE) || (i_r == last_idx)) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_GCD_PICK;
        end
      end
      ST_OUT: begin
        if (!res_valid_r) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Output and datapath control.
  always_comb begin
    q_pop         = 1'b0;
    div_req       = '0;
    gcd_req       = '0;
    store_we      = 1'b0;
    lane_we       = 1'b0;
    cov_step      = 1'b0;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    cur_last_nxt  = cur_last_r;
    used_nxt      = used_r;
    lim_nxt       = lim_r;
    t_nxt         = t_r;
    top_nxt       = top_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    g_nxt         = g_r;
    gcd_ok_nxt    = gcd_ok_r;
    cov_nxt       = cov_r;
    res_valid_nxt = res_valid_r;
    v_cover_nxt   = v_cover_r;
    v_gcd_nxt     = v_gcd_r;
    v_cov_nxt     = v_cov_r;
    v_bad_nxt     = v_bad_r;

    // The consumer takes the waiting verdict.
    if (out_pop && res_valid_r) begin
      res_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          err_nxt      = err_r | q_item.err;
          cur_last_nxt = q_item.last;
          if (!q_item.drop) begin
            store_we         = 1'b1;
            div_req.start    = 1'b1;
            div_req.dividend = q_item.speed;
            div_req.divisor  = modulus;
          end
        end
      end
      ST_MOD: begin
        if (div_rsp.done) begin
          lane_we           = 1'b1;
          used_nxt[cnt_idx] = 1'b1;
          cnt_nxt           = cnt_r + CW'(1);
        end
      end
      ST_THR: begin
        div_req.start    = 1'b1;
        div_req.dividend = modulus - ONE;
        div_req.divisor  = DATA_W'(cnt_r) + ONE;
      end
      ST_THR_WAIT: begin
        if (div_rsp.done) begin
          lim_nxt = div_rsp.quot;
        end
      end
      ST_COV_INIT: begin
        t_nxt   = ONE;
        top_nxt = top_val;
        cov_nxt = 1'b1;
      end
      ST_COV: begin
        if (!any_hit) begin
          cov_nxt = 1'b0;
        end else if (t_r != top_r) begin
          t_nxt    = t_r + ONE;
          cov_step = 1'b1;
        end
      end
      ST_GCD_INIT: begin
        i_nxt = '0;
        j_nxt = '0;
        g_nxt = level_ext;
      end
      ST_GCD_PICK: begin
        if (!skip_j) begin
          gcd_req.start = 1'b1;
          gcd_req.a     = g_r;
          gcd_req.b     = store_r[j_r];
        end else if (!j_at_end) begin
          j_nxt = j_r + IW'(1);
        end
      end
      ST_GCD_WAIT: begin
        if (gcd_rsp.done) begin
          g_nxt = gcd_rsp.g;
          if (!j_at_end) begin
            j_nxt = j_r + IW'(1);
          end
        end
      end
      ST_GCD_CHECK: begin
        if (g_r != ONE) begin
          gcd_ok_nxt = 1'b0;
        end else if (i_r == last_idx) begin
          gcd_ok_nxt = 1'b1;
        end else begin
          i_nxt = i_r + IW'(1);
          j_nxt = '0;
          g_nxt = level_ext;
        end
      end
      ST_OUT: begin
        if (!res_valid_r) begin
          res_valid_nxt = 1'b1;
          v_gcd_nxt     = gcd_ok_r;
          v_cov_nxt     = cov_r;
          v_bad_nxt     = err_r;
          v_cover_nxt   = gcd_ok_r && cov_r && !err_r;
          cnt_nxt       = '0;
          err_nxt       = 1'b0;
          used_nxt      = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      cur_last_r  <= 1'b0;
      used_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      cur_last_r  <= cur_last_nxt;
      used_r      <= used_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r     <= lim_nxt;
    t_r       <= t_nxt;
    top_r     <= top_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    g_r       <= g_nxt;
    gcd_ok_r  <= gcd_ok_nxt;
    cov_r     <= cov_nxt;
    v_cover_r <= v_cover_nxt;
    v_gcd_r   <= v_gcd_nxt;
    v_cov_r   <= v_cov_nxt;
    v_bad_r   <= v_bad_nxt;
  end

  // Store and lane arrays.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[cnt_idx] <= q_item.speed;
    end
    if (lane_we) begin
      mres_r[cnt_idx] <= div_rsp.rem;
    end
    for (int k = 0; k < MAX_RUNNERS; k++) begin
      if (cov_step) begin
        res_r[k] <= step_val[k];
      end
    end
    if (lane_we) begin
      res_r[cnt_idx] <= div_rsp.rem;
    end
  end

  assign out_empty       = !res_valid_r;
  assign out_is_cover    = v_cover_r;
  assign out_gcd_ok      = v_gcd_r;
  assign out_coverage_ok = v_cov_r;
  assign out_bad_tuple   = v_bad_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the speed tuple cover checker. A table of directed
// tuples walks the register extremes and the corner cases. Phases of random
// tuples then follow, each under random register settings. An internal model
// of coverage and subset gcd predicts every verdict, and each popped verdict
// is compared field by field. Both channels may idle in random bursts, except
// in the final phase.
// ----------------------------------------------------------------------------
module tb_top;
  import stcc_pkg::*;

  localparam int          TUPLE_CAP     = 16;
  localparam int          PHASES        = 10;
  localparam int          PHASE_ITEMS   = 70;
  localparam int          SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT   = 10_000_000;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Field order matches the result ports: is_cover, gcd_ok, coverage_ok, bad_tuple.
  typedef struct packed {
    logic is_cover;
    logic gcd_ok;
    logic coverage_ok;
    logic bad_tuple;
  } verdict_t;

  // Per speed transaction: whether its verdict was typed into the plan.
  typedef struct {
    bit       typed;
    verdict_t verdict;
  } speed_note_t;

  typedef enum bit {ROW_SPEED, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    value;
    logic                 last;
    bit                   typed;
    verdict_t             verdict;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_wdata = '0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [DATA_W-1:0]    in_speed = '0;
  logic                 in_last = 1'b0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic                 out_is_cover;
  logic                 out_gcd_ok;
  logic                 out_coverage_ok;
  logic                 out_bad_tuple;

  // Predictor state: register copies and the tuple gathered so far.
  logic [DATA_W-1:0]  ring_size;
  logic [LEVEL_W-1:0] gcd_partner;
  logic               whole_ring;
  logic [DATA_W-1:0]  held_speeds [TUPLE_CAP];
  int unsigned        held_count;
  logic               held_bad;

  verdict_t     verdict_q [$];
  speed_note_t  note_q [$];
  plan_row_t    plan [$];
  speed_note_t  cur_note;
  verdict_t     predicted;
  int unsigned  fail_count = 0;
  int unsigned  cycle_count;
  int unsigned  gap_rate = 0;
  int unsigned  stall_rate = 0;
  int unsigned  pop_hold = 0;
  bit           quiet_tail = 1'b0;

  speed_tuple_cover_checker_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_speed        (in_speed),
    .in_last         (in_last),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_is_cover    (out_is_cover),
    .out_gcd_ok      (out_gcd_ok),
    .out_coverage_ok (out_coverage_ok),
    .out_bad_tuple   (out_bad_tuple)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned gcd_of(input int unsigned a, input int unsigned b);
    int unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Dropping any one speed must leave a set whose gcd is coprime to the level.
  function automatic bit subsets_coprime();
    int unsigned g;
    for (int i = 0; i < held_count; i++) begin
      g = 0;
      for (int j = 0; j < held_count; j++)
        if (j != i) g = gcd_of(g, held_speeds[j]);
      if (gcd_of(g, gcd_partner) != 1) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Every position must land within Q/(c+1) of zero for at least one speed.
  function automatic bit ring_covered();
    longint unsigned q, top, mul, r;
    bit hit;
    q = ring_size;
    if (q == 0) return 1'b1;
    top = whole_ring ? q : q / 2;
    mul = held_count + 1;
    for (longint unsigned t = 1; t <= top; t++) begin
      hit = 1'b0;
      for (int j = 0; j < held_count && !hit; j++) begin
        r = (t * held_speeds[j]) % q;
        if (r * mul < q || (q - r) * mul < q) hit = 1'b1;
      end
      if (!hit) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Takes one speed into the tuple; returns 1 with a verdict when it closes it.
  function automatic bit absorb_speed(input logic [DATA_W-1:0] s, input logic l,
                                      output verdict_t v);
    v = '0;
    if (s >= ring_size) held_bad = 1'b1;
    if (held_count < TUPLE_CAP) begin
      held_speeds[held_count] = s;
      held_count++;
    end else begin
      held_bad = 1'b1;
    end
    if (!l) return 1'b0;
    v.gcd_ok      = subsets_coprime();
    v.coverage_ok = ring_covered();
    v.bad_tuple   = held_bad;
    v.is_cover    = v.gcd_ok & v.coverage_ok & ~v.bad_tuple;
    held_count    = 0;
    held_bad      = 1'b0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Observation: register writes, accepted speeds and popped verdicts.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      ring_size   = 16'd2710;
      gcd_partner = 8'd10;
      whole_ring  = 1'b1;
      held_count  = 0;
      held_bad    = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODULUS:    ring_size = cfg_wdata;
          REG_LEVEL:      gcd_partner = cfg_wdata[LEVEL_W-1:0];
          REG_FULL_RANGE: whole_ring = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        if (note_q.size() != 0)
          cur_note = note_q.pop_front();
        else
          cur_note = '{1'b0, '0};
        if (absorb_speed(in_speed, in_last, predicted))
          verdict_q.insert(verdict_q.size(), cur_note.typed ? cur_note.verdict : predicted);
      end
      if (out_pop && !out_empty) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict with none expected, actual %b%b%b%b", $time,
                   out_is_cover, out_gcd_ok, out_coverage_ok, out_bad_tuple);
          fail_count++;
        end else begin
          predicted = verdict_q.pop_front();
          check_field("is_cover", predicted.is_cover, out_is_cover);
          check_field("gcd_ok", predicted.gcd_ok, out_gcd_ok);
          check_field("coverage_ok", predicted.coverage_ok, out_coverage_ok);
          check_field("bad_tuple", predicted.bad_tuple, out_bad_tuple);
        end
      end
    end
  end

  // Result side: pop stalls in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_hold = 0;
    end else if (quiet_tail || stall_rate == 0) begin
      out_pop <= 1'b1;
    end else if (pop_hold != 0) begin
      out_pop <= 1'b0;
      pop_hold--;
    end else if ($urandom_range(stall_rate - 1) == 0) begin
      out_pop <= 1'b0;
      pop_hold = $urandom_range(0, 12);
    end else begin
      out_pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DATA_W-1:0] val);
    plan_row_t row;
    row = '{ROW_WRITE, idx, val, 1'b0, 1'b0, '0};
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_speed(input logic [DATA_W-1:0] s, input logic l);
    plan_row_t row;
    row = '{ROW_SPEED, REG_MODULUS, s, l, 1'b0, '0};
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_judged(input logic [DATA_W-1:0] s, input verdict_t v);
    plan_row_t row;
    row = '{ROW_SPEED, REG_MODULUS, s, 1'b1, 1'b1, v};
    plan.insert(plan.size(), row);
  endfunction

  // Waits until every verdict has been popped, then lets the block settle.
  task automatic drain_verdicts();
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    in_push <= 1'b0;
    drain_verdicts();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Holds one speed transaction on the input until the block takes it.
  task automatic send_speed(input logic [DATA_W-1:0] s, input logic l,
                            input speed_note_t note);
    note_q.insert(note_q.size(), note);
    in_push  <= 1'b1;
    in_speed <= s;
    in_last  <= l;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Input side: optional idle burst after a transaction.
  task automatic pace_input();
    if (!quiet_tail && gap_rate != 0 && $urandom_range(gap_rate - 1) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  function automatic int unsigned pick_rate();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 3;
      2:       return 8;
      default: return 25;
    endcase
  endfunction

  // Mostly small rings keep the position sweep short.
  function automatic int unsigned pick_modulus();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return $urandom_range(1, 3);
    if (r < 45) return $urandom_range(4, 40);
    if (r < 85) return $urandom_range(41, 400);
    return $urandom_range(401, 2000);
  endfunction

  // Level 1 often, so that the gcd test can pass and full covers appear.
  function automatic int unsigned pick_level();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return 1;
    if (r < 70) return $urandom_range(2, 12);
    return $urandom_range(0, 255);
  endfunction

  function automatic int unsigned pick_tuple_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, TUPLE_CAP);
    return $urandom_range(TUPLE_CAP + 1, TUPLE_CAP + 3);
  endfunction

  // Mostly valid speeds, some at or just past the modulus, some anywhere.
  function automatic logic [DATA_W-1:0] pick_speed(input int unsigned q);
    int unsigned r;
    r = $urandom_range(99);
    if (q >= 1 && r < 80) return DATA_W'($urandom_range(0, q - 1));
    if (r < 90) return DATA_W'(q + $urandom_range(0, 3));
    return DATA_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Cycle limit for a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned q;
    int unsigned sent;
    int unsigned len;
    speed_note_t plain;

    plain = '{1'b0, '0};
    gap_rate   = 3;
    stall_rate = 4;

    // Reset defaults: a speed equal to Q is flagged, level 10 fails the gcd.
    add_judged(16'd2710, verdict_t'{1'b0, 1'b0, 1'b1, 1'b1});
    // Single speed 1 under even Q misses position Q/2; the spare index is inert.
    add_write(REG_LEVEL, 16'd1);
    add_write(REG_SPARE, 16'hFFFF);
    add_judged(16'd1, verdict_t'{1'b0, 1'b1, 1'b0, 1'b0});
    // Odd Q covered by speed 1; speed equal to Q is bad.
    add_write(REG_MODULUS, 16'd3);
    add_judged(16'd1, verdict_t'{1'b1, 1'b1, 1'b1, 1'b0});
    add_judged(16'd3, verdict_t'{1'b0, 1'b1, 1'b1, 1'b1});
    // Smallest ring, then half range with speed zero.
    add_write(REG_MODULUS, 16'd2);
    add_judged(16'd1, verdict_t'{1'b0, 1'b1, 1'b0, 1'b0});
    add_write(REG_FULL_RANGE, 16'd0);
    add_speed(16'd0, 1'b1);
    // Modulus zero: nothing to cover, every speed is out of range.
    add_write(REG_MODULUS, 16'd0);
    add_judged(16'd5, verdict_t'{1'b0, 1'b1, 1'b1, 1'b1});
    // Level zero: each leave-one-out subset must have gcd 1 by itself.
    add_write(REG_MODULUS, 16'd7);
    add_write(REG_LEVEL, 16'd0);
    add_write(REG_FULL_RANGE, 16'd1);
    add_speed(16'd2, 1'b0);
    add_speed(16'd3, 1'b1);
    // Largest ring and level with one speed past capacity.
    add_write(REG_MODULUS, 16'hFFFF);
    add_write(REG_LEVEL, 16'd255);
    add_speed(16'hFFFE, 1'b0);
    for (int k = 1; k < TUPLE_CAP; k++) add_speed(DATA_W'(k * 4093), 1'b0);
    add_speed(16'hFFFF, 1'b1);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_speed(plan[i].value, plan[i].last, '{plan[i].typed, plan[i].verdict});
        pace_input();
      end
    end

    // Random phases, each under fresh settings; the last one runs without idling.
    for (int p = 0; p < PHASES; p++) begin
      q = pick_modulus();
      write_reg(REG_MODULUS, DATA_W'(q));
      write_reg(REG_LEVEL, DATA_W'(pick_level()));
      write_reg(REG_FULL_RANGE, DATA_W'($urandom_range(1)));
      quiet_tail = (p == PHASES - 1);
      gap_rate   = pick_rate();
      stall_rate = pick_rate();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = pick_tuple_len();
        for (int k = 1; k <= len; k++) begin
          send_speed(pick_speed(q), k == len, plain);
          sent++;
          pace_input();
        end
      end
    end

    in_push <= 1'b0;
    drain_verdicts();
    if (fail_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/stcc_pkg.sv
design/stcc_front.sv
design/stcc_divu.sv
design/stcc_gcd.sv
design/stcc_back.sv
design/speed_tuple_cover_checker_top.sv
tb/tb_top.sv
